>>> rtl/core/stereo_ring_buffer_linear_resampler_defines.svh
// Assertion macros shared by the resampler RTL.
`ifndef STEREO_RING_BUFFER_LINEAR_RESAMPLER_DEFINES_SVH
`define STEREO_RING_BUFFER_LINEAR_RESAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
`define SRBL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srbl: same-cycle check failed");
`define SRBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srbl: next-cycle check failed");
`else
`define SRBL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SRBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/srbl_pkg.sv
package srbl_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int RATIO_BITS  = 20;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_BITS    = 8;
    localparam int FRAMES_BITS = 11;

    localparam logic [RATIO_BITS-1:0] RATIO_UNITY = RATIO_BITS'(65536);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_RESULT
    } t_cmd_kind;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_MUL,
        FE_PUSH
    } t_fe_state;

    typedef struct packed {
        t_op                 op;
        t_sample             left_in;
        t_sample             right_in;
        logic [NUM_BITS-1:0] num_frames;
    } t_in_word;

    typedef struct packed {
        t_sample                left_out;
        t_sample                right_out;
        logic                   last;
        t_status                status;
        logic [FRAMES_BITS-1:0] frames_consumed;
        logic [FRAMES_BITS-1:0] frames_available;
    } t_out_word;

    typedef struct packed {
        t_cmd_kind           kind;
        t_status             status;
        t_sample             left;
        t_sample             right;
        logic [NUM_BITS-1:0] num;
    } t_cmd;

endpackage

>>> rtl/core/srbl_front.sv
`include "stereo_ring_buffer_linear_resampler_defines.svh"

module srbl_front #(
    parameter int CAPACITY  = 1024,
    parameter int MAX_BLOCK = 64,
    parameter int AW        = 10,
    parameter int CW        = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  srbl_pkg::t_in_word                i_in_data,
    input  logic [srbl_pkg::RATIO_BITS-1:0]   i_ratio,
    output logic                              o_q_valid,
    input  logic                              i_q_ready,
    output srbl_pkg::t_cmd                    o_q_cmd,
    output logic [AW-1:0]                     o_q_addr,
    output logic [CW-1:0]                     o_q_need,
    output logic [CW-1:0]                     o_q_avail
);
    import srbl_pkg::*;

    localparam int PRODW = NUM_BITS + RATIO_BITS;
    localparam int NEEDW = PRODW + 1 - FRAC_BITS;
    localparam int CMPW  = (NEEDW > CW) ? NEEDW : CW;
    localparam logic [PRODW:0] ROUND = (PRODW + 1)'((2 ** FRAC_BITS) - 1);

    t_fe_state         r_state, n_state;
    t_in_word          r_item;
    logic [PRODW-1:0]  r_prod;
    logic [AW-1:0]     r_rp, r_wp, n_rp, n_wp;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              accept, mul_en, push;
    logic [PRODW:0]    prod_rnd;
    logic [NEEDW-1:0]  need;
    logic [CW-1:0]     need_c;
    logic              reject, full;
    logic [CW:0]       rp_sum, rp_wrap;
    logic [AW-1:0]     wp_inc;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FE_IDLE: begin
                if (i_in_valid) n_state = FE_MUL;
            end
            FE_MUL: n_state = FE_PUSH;
            FE_PUSH: begin
                if (i_q_ready) n_state = FE_IDLE;
            end
            default: n_state = FE_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != FE_IDLE);
        mul_en     = (r_state == FE_MUL);
        o_q_valid  = (r_state == FE_PUSH);
        accept     = i_in_valid && (r_state == FE_IDLE);
        push       = o_q_valid && i_q_ready;
    end

    always_comb begin
        prod_rnd = {1'b0, r_prod} + ROUND;
        need     = prod_rnd[PRODW:FRAC_BITS];
        need_c   = CW'(need);
        reject   = (r_item.num_frames > NUM_BITS'(MAX_BLOCK)) ||
                   (CMPW'(need) > CMPW'(r_cnt));
        full     = (r_cnt >= CW'(CAPACITY));
        rp_sum   = (CW + 1)'(r_rp) + (CW + 1)'(need_c);
        rp_wrap  = (rp_sum >= (CW + 1)'(CAPACITY)) ? rp_sum - (CW + 1)'(CAPACITY) : rp_sum;
        wp_inc   = (r_wp == AW'(CAPACITY - 1)) ? '0 : r_wp + AW'(1);
    end

    always_comb begin
        n_rp          = r_rp;
        n_wp          = r_wp;
        n_cnt         = r_cnt;
        o_q_cmd.kind   = CMD_RESULT;
        o_q_cmd.status = ST_OK;
        o_q_cmd.left   = r_item.left_in;
        o_q_cmd.right  = r_item.right_in;
        o_q_cmd.num    = r_item.num_frames;
        o_q_addr      = r_rp;
        o_q_need      = '0;
        o_q_avail     = r_cnt;
        unique case (r_item.op)
            OP_WRITE: begin
                if (full) begin
                    o_q_cmd.status = ST_FULL;
                end else begin
                    o_q_cmd.kind = CMD_WRITE;
                    o_q_addr     = r_wp;
                    n_wp         = wp_inc;
                    n_cnt        = r_cnt + CW'(1);
                    o_q_avail    = n_cnt;
                end
            end
            OP_READ: begin
                if (reject) begin
                    o_q_cmd.status = ST_REJECT;
                end else if (r_item.num_frames != '0) begin
                    o_q_cmd.kind = CMD_READ;
                    o_q_need     = need_c;
                    n_rp         = AW'(rp_wrap);
                    n_cnt        = r_cnt - need_c;
                    o_q_avail    = n_cnt;
                end
            end
            OP_CLEAR: begin
                n_rp      = '0;
                n_wp      = '0;
                n_cnt     = '0;
                o_q_avail = '0;
            end
            OP_QUERY: begin
                o_q_avail = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
            r_rp    <= '0;
            r_wp    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_rp  <= n_rp;
                r_wp  <= n_wp;
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_item <= i_in_data;
        if (mul_en) r_prod <= PRODW'(r_item.num_frames) * PRODW'(i_ratio);
    end

    `SRBL_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(CAPACITY))
    `SRBL_ASSERT_IMP(a_ring_sum, i_clk, i_rst_n, 1'b1, ((CW + 1)'(r_rp) + (CW + 1)'(r_cnt) == (CW + 1)'(r_wp)) || ((CW + 1)'(r_rp) + (CW + 1)'(r_cnt) == (CW + 1)'(r_wp) + (CW + 1)'(CAPACITY)))

endmodule

>>> rtl/core/srbl_queue.sv
module srbl_queue #(
    parameter int AW = 10,
    parameter int CW = 11
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  srbl_pkg::t_cmd i_cmd,
    input  logic [AW-1:0]  i_addr,
    input  logic [CW-1:0]  i_need,
    input  logic [CW-1:0]  i_avail,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output srbl_pkg::t_cmd o_cmd,
    output logic [AW-1:0]  o_addr,
    output logic [CW-1:0]  o_need,
    output logic [CW-1:0]  o_avail
);
    import srbl_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    t_cmd          r_cmd   [DEPTH];
    logic [AW-1:0] r_addr  [DEPTH];
    logic [CW-1:0] r_need  [DEPTH];
    logic [CW-1:0] r_avail [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [PW:0]   r_fill;
    logic          push, pop;

    assign o_push_ready = (r_fill != (PW + 1)'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    assign o_cmd   = r_cmd[r_rd_ptr];
    assign o_addr  = r_addr[r_rd_ptr];
    assign o_need  = r_need[r_rd_ptr];
    assign o_avail = r_avail[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + PW'(1);
            if (pop)  r_rd_ptr <= r_rd_ptr + PW'(1);
            if (push && !pop) begin
                r_fill <= r_fill + (PW + 1)'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - (PW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_cmd[r_wr_ptr]   <= i_cmd;
            r_addr[r_wr_ptr]  <= i_addr;
            r_need[r_wr_ptr]  <= i_need;
            r_avail[r_wr_ptr] <= i_avail;
        end
    end

endmodule

>>> rtl/core/srbl_back.sv
`include "stereo_ring_buffer_linear_resampler_defines.svh"

module srbl_back #(
    parameter int CAPACITY  = 1024,
    parameter int MAX_BLOCK = 64,
    parameter int AW        = 10,
    parameter int CW        = 11
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [srbl_pkg::RATIO_BITS-1:0] i_ratio,
    input  logic                            i_q_valid,
    output logic                            o_q_ready,
    input  srbl_pkg::t_cmd                  i_q_cmd,
    input  logic [AW-1:0]                   i_q_addr,
    input  logic [CW-1:0]                   i_q_need,
    input  logic [CW-1:0]                   i_q_avail,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output srbl_pkg::t_out_word             o_out_data
);
    import srbl_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int POS_W = $clog2(MAX_BLOCK) + RATIO_BITS;
    localparam int IXW   = POS_W - FRAC_BITS;
    localparam int SW    = ((AW > IXW) ? AW : IXW) + 1;
    localparam int DW    = SB + 1;
    localparam int PW    = DW + FRAC_BITS + 1;
    localparam int HIW   = PW - FRAC_BITS;

    typedef struct packed {
        logic                 valid;
        logic                 rd;
        logic [FRAC_BITS-1:0] frac;
        logic                 v1;
        logic                 v2;
        logic                 last;
        t_status              status;
        logic [CW-1:0]        consumed;
        logic [CW-1:0]        avail;
    } t_tok;

    logic [2*SB-1:0]       mem [CAPACITY];
    logic [2*SB-1:0]       r_rd1, r_rd2;
    logic [NUM_BITS-1:0]   r_i;
    logic [POS_W-1:0]      r_pos;
    logic [CW-1:0]         r_hw;
    t_tok                  iss, r_a, r_b, r_c;
    logic                  advance, is_read, is_write, seq_last, wr_en;
    logic [IXW-1:0]        idx;
    logic [SW-1:0]         sum;
    logic [AW-1:0]         p1, p2;
    t_sample               s1l, s1r, s2l, s2r;
    t_sample               r_b_s1l, r_b_s1r, r_c_s1l, r_c_s1r;
    logic signed [DW-1:0]  r_b_dl, r_b_dr;
    logic signed [FRAC_BITS:0] frac_s;
    logic signed [PW-1:0]  r_c_pl, r_c_pr;
    logic                  r_out_valid;
    t_out_word             r_out;

    assign advance = !r_out_valid || !i_out_stall;

    always_comb begin
        is_read  = (i_q_cmd.kind == CMD_READ);
        is_write = (i_q_cmd.kind == CMD_WRITE);
        seq_last = !is_read || ((r_i + NUM_BITS'(1)) == i_q_cmd.num);
        idx      = r_pos[POS_W-1:FRAC_BITS];
        sum      = SW'(i_q_addr) + SW'(idx);
        p1       = (sum >= SW'(CAPACITY)) ? AW'(sum - SW'(CAPACITY)) : AW'(sum);
        p2       = (p1 == AW'(CAPACITY - 1)) ? '0 : p1 + AW'(1);
        wr_en    = advance && i_q_valid && is_write;
        o_q_ready = advance && i_q_valid && seq_last;

        iss.valid    = i_q_valid;
        iss.rd       = is_read;
        iss.frac     = r_pos[FRAC_BITS-1:0];
        iss.v1       = (CW'(p1) < r_hw);
        iss.v2       = (CW'(p2) < r_hw);
        iss.last     = seq_last;
        iss.status   = i_q_cmd.status;
        iss.consumed = (is_read && seq_last) ? i_q_need : '0;
        iss.avail    = (is_read && !seq_last) ? i_q_avail + i_q_need : i_q_avail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i   <= '0;
            r_pos <= '0;
            r_hw  <= '0;
        end else begin
            if (advance && i_q_valid && is_read) begin
                if (seq_last) begin
                    r_i   <= '0;
                    r_pos <= '0;
                end else begin
                    r_i   <= r_i + NUM_BITS'(1);
                    r_pos <= r_pos + POS_W'(i_ratio);
                end
            end
            if (wr_en && (CW'(i_q_addr) >= r_hw)) r_hw <= CW'(i_q_addr) + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[i_q_addr] <= {i_q_cmd.left, i_q_cmd.right};
        if (advance) begin
            r_rd1 <= mem[p1];
            r_rd2 <= mem[p2];
        end
    end

    always_comb begin
        s1l = (r_a.rd && r_a.v1) ? t_sample'(r_rd1[2*SB-1:SB]) : '0;
        s1r = (r_a.rd && r_a.v1) ? t_sample'(r_rd1[SB-1:0])    : '0;
        s2l = (r_a.rd && r_a.v2) ? t_sample'(r_rd2[2*SB-1:SB]) : '0;
        s2r = (r_a.rd && r_a.v2) ? t_sample'(r_rd2[SB-1:0])    : '0;
        frac_s = $signed({1'b0, r_b.frac});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= '0;
            r_b         <= '0;
            r_c         <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_a         <= iss;
            r_b         <= r_a;
            r_c         <= r_b;
            r_out_valid <= r_c.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b_s1l <= s1l;
            r_b_s1r <= s1r;
            r_b_dl  <= DW'(s2l) - DW'(s1l);
            r_b_dr  <= DW'(s2r) - DW'(s1r);
            r_c_s1l <= r_b_s1l;
            r_c_s1r <= r_b_s1r;
            r_c_pl  <= r_b_dl * frac_s;
            r_c_pr  <= r_b_dr * frac_s;
            r_out.left_out         <= SB'(HIW'(r_c_s1l) + r_c_pl[PW-1:FRAC_BITS]);
            r_out.right_out        <= SB'(HIW'(r_c_s1r) + r_c_pr[PW-1:FRAC_BITS]);
            r_out.last             <= r_c.last;
            r_out.status           <= r_c.status;
            r_out.frames_consumed  <= FRAMES_BITS'(r_c.consumed);
            r_out.frames_available <= FRAMES_BITS'(r_c.avail);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SRBL_ASSERT_IMP(a_hw_bound, i_clk, i_rst_n, 1'b1, r_hw <= CW'(CAPACITY))
    `SRBL_ASSERT_IMP(a_seq_index, i_clk, i_rst_n, i_q_valid && (i_q_cmd.kind == CMD_READ), r_i < i_q_cmd.num)
    `SRBL_ASSERT_NEXT(a_write_marks, i_clk, i_rst_n, wr_en, r_hw > CW'($past(i_q_addr)))
    `SRBL_ASSERT_IMP(a_zero_on_status, i_clk, i_rst_n, r_out_valid && (r_out.status != ST_OK), (r_out.left_out == '0) && (r_out.right_out == '0))

endmodule

>>> rtl/core/stereo_ring_buffer_linear_resampler.sv
// Stereo frame ring buffer with linear-interpolation read-out.
// Input channel (i_in_valid / o_in_stall / i_in_data): one word per op:
// write a frame, read a block of num_frames interpolated frames, clear the
// pointers, or query the held count. Output channel (o_out_valid /
// i_out_stall / o_out_data): one word per write, clear, query, rejected or
// zero-frame read, num_frames words per good read, last set on the final one.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) sets rate_ratio,
// Q4.16; o_cfg_ready is always high. Write it only while the block is idle.
// Front end steps each word through accept, ratio multiply and classify, taking
// no new word until it hands the command to a two-entry queue. The back end
// then runs issue and memory read, difference, multiply and output register;
// a read streams one word per cycle, while the output is not stalled, from the
// two-read-port frame memory.
// Reset clears pointers, count and ratio (unity). The frame memory is not
// swept: entries not written since reset read as zero via a written-extent
// mark, so the block takes input right after reset.
// Output stall freezes the back-end pipeline; the queue fills, then
// o_in_stall holds the front end.
module stereo_ring_buffer_linear_resampler #(
    parameter int CAPACITY  = 1024,
    parameter int MAX_BLOCK = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  srbl_pkg::t_in_word              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output srbl_pkg::t_out_word             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srbl_pkg::RATIO_BITS-1:0] i_cfg_data
);
    import srbl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [RATIO_BITS-1:0] r_ratio;
    logic                  fq_valid, fq_ready, qb_valid, qb_ready;
    t_cmd                  fq_cmd, qb_cmd;
    logic [AW-1:0]         fq_addr, qb_addr;
    logic [CW-1:0]         fq_need, fq_avail, qb_need, qb_avail;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_UNITY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ratio <= i_cfg_data;
        end
    end

    srbl_front #(
        .CAPACITY  (CAPACITY),
        .MAX_BLOCK (MAX_BLOCK),
        .AW        (AW),
        .CW        (CW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_ratio    (r_ratio),
        .o_q_valid  (fq_valid),
        .i_q_ready  (fq_ready),
        .o_q_cmd    (fq_cmd),
        .o_q_addr   (fq_addr),
        .o_q_need   (fq_need),
        .o_q_avail  (fq_avail)
    );

    srbl_queue #(
        .AW (AW),
        .CW (CW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_cmd        (fq_cmd),
        .i_addr       (fq_addr),
        .i_need       (fq_need),
        .i_avail      (fq_avail),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_cmd        (qb_cmd),
        .o_addr       (qb_addr),
        .o_need       (qb_need),
        .o_avail      (qb_avail)
    );

    srbl_back #(
        .CAPACITY  (CAPACITY),
        .MAX_BLOCK (MAX_BLOCK),
        .AW        (AW),
        .CW        (CW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ratio     (r_ratio),
        .i_q_valid   (qb_valid),
        .o_q_ready   (qb_ready),
        .i_q_cmd     (qb_cmd),
        .i_q_addr    (qb_addr),
        .i_q_need    (qb_need),
        .i_q_avail   (qb_avail),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> verif/stereo_ring_buffer_linear_resampler_test.sv
module stereo_ring_buffer_linear_resampler_test;

    import srbl_pkg::*;

    localparam int CAP            = 1024;
    localparam int MAX_BLK        = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_LEN   = 400;

    typedef struct packed {
        t_op                    op;
        t_sample                left;
        t_sample                right;
        logic [NUM_BITS-1:0]    num;
        logic                   typed;
        t_status                status;
        logic [FRAMES_BITS-1:0] avail;
    } t_dir_row;

    t_dir_row plan [20] = '{
        '{OP_QUERY, 24'h000000, 24'h000000, 8'd0,   1'b1, ST_OK,     11'd0},
        '{OP_READ,  24'h000000, 24'h000000, 8'd1,   1'b1, ST_REJECT, 11'd0},
        '{OP_READ,  24'h000000, 24'h000000, 8'd0,   1'b1, ST_OK,     11'd0},
        '{OP_WRITE, 24'h7FFFFF, 24'h800000, 8'd0,   1'b1, ST_OK,     11'd1},
        '{OP_WRITE, 24'h800000, 24'h7FFFFF, 8'd0,   1'b1, ST_OK,     11'd2},
        '{OP_WRITE, 24'h000000, 24'hFFFFFF, 8'd0,   1'b1, ST_OK,     11'd3},
        '{OP_WRITE, 24'hFFFFFF, 24'h000001, 8'd0,   1'b1, ST_OK,     11'd4},
        '{OP_READ,  24'h000000, 24'h000000, 8'd65,  1'b1, ST_REJECT, 11'd4},
        '{OP_READ,  24'h000000, 24'h000000, 8'd255, 1'b1, ST_REJECT, 11'd4},
        '{OP_READ,  24'h000000, 24'h000000, 8'd5,   1'b1, ST_REJECT, 11'd4},
        '{OP_READ,  24'h000000, 24'h000000, 8'd2,   1'b0, ST_OK,     11'd0},
        '{OP_READ,  24'h000000, 24'h000000, 8'd2,   1'b0, ST_OK,     11'd0},
        '{OP_QUERY, 24'h000000, 24'h000000, 8'd0,   1'b1, ST_OK,     11'd0},
        '{OP_WRITE, 24'h123456, 24'hEDCBA9, 8'd0,   1'b1, ST_OK,     11'd1},
        '{OP_CLEAR, 24'h000000, 24'h000000, 8'd0,   1'b1, ST_OK,     11'd0},
        '{OP_WRITE, 24'h400000, 24'hC00000, 8'd0,   1'b1, ST_OK,     11'd1},
        '{OP_READ,  24'h000000, 24'h000000, 8'd1,   1'b0, ST_OK,     11'd0},
        '{OP_READ,  24'h000000, 24'h000000, 8'd0,   1'b1, ST_OK,     11'd0},
        '{OP_READ,  24'h000000, 24'h000000, 8'd64,  1'b1, ST_REJECT, 11'd0},
        '{OP_QUERY, 24'hFFFFFF, 24'hFFFFFF, 8'd255, 1'b1, ST_OK,     11'd0}
    };

    int ratio_list [9] = '{32768, 0, 1, 98304, 65536, 1048575, -1, -1, 21845};

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_word              in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_out_word             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [RATIO_BITS-1:0] cfg_data;

    t_sample               ring_left  [CAP];
    t_sample               ring_right [CAP];
    int                    ring_rd;
    int                    ring_wr;
    int                    ring_held;
    logic [RATIO_BITS-1:0] ratio_q;

    t_out_word             pred_words [$];
    t_out_word             expected_words [$];
    t_out_word             head_word;

    int error_count   = 0;
    int words_seen    = 0;
    int quiet_cycles  = 0;
    int send_pct;
    int stall_pct;
    int hold_off_asks;

    stereo_ring_buffer_linear_resampler i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(40, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(11))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_sample blend(t_sample a, t_sample b, logic [FRAC_BITS-1:0] frac);
        longint d;
        d = (longint'(b) - longint'(a)) * longint'(frac);
        return t_sample'(longint'(a) + (d >>> FRAC_BITS));
    endfunction

    // Advance the ring state by one word and collect the words it must produce.
    task automatic predict_word(input t_in_word w);
        t_out_word o;
        longint    need;
        longint    pos;
        int        idx;
        int        p1;
        int        p2;
        int        i;
        pred_words.delete();
        o = '0;
        o.last = 1'b1;
        o.status = ST_OK;
        case (w.op)
            OP_WRITE: begin
                if (ring_held >= CAP) begin
                    o.status = ST_FULL;
                end else begin
                    ring_left[ring_wr] = w.left_in;
                    ring_right[ring_wr] = w.right_in;
                    ring_wr = (ring_wr + 1) % CAP;
                    ring_held++;
                end
            end
            OP_CLEAR: begin
                ring_rd = 0;
                ring_wr = 0;
                ring_held = 0;
            end
            OP_READ: begin
                need = (longint'(w.num_frames) * longint'(ratio_q) + 65535) >>> FRAC_BITS;
                if (w.num_frames > MAX_BLK || need > ring_held) begin
                    o.status = ST_REJECT;
                end else if (w.num_frames != 0) begin
                    for (i = 0; i < int'(w.num_frames); i++) begin
                        pos = longint'(i) * longint'(ratio_q);
                        idx = int'(pos >>> FRAC_BITS);
                        p1 = (ring_rd + idx) % CAP;
                        p2 = (ring_rd + idx + 1) % CAP;
                        o.left_out = blend(ring_left[p1], ring_left[p2], pos[FRAC_BITS-1:0]);
                        o.right_out = blend(ring_right[p1], ring_right[p2], pos[FRAC_BITS-1:0]);
                        o.last = (i == int'(w.num_frames) - 1);
                        o.frames_consumed = '0;
                        if (o.last) begin
                            ring_rd = int'((longint'(ring_rd) + need) % CAP);
                            ring_held = ring_held - int'(need);
                            o.frames_consumed = FRAMES_BITS'(need);
                        end
                        o.frames_available = FRAMES_BITS'(ring_held);
                        pred_words.push_back(o);
                    end
                    return;
                end
            end
            default: ;
        endcase
        o.frames_available = FRAMES_BITS'(ring_held);
        pred_words.push_back(o);
    endtask

    function automatic t_in_word random_word();
        t_in_word    w;
        int unsigned pick;
        longint      room;
        w.left_in = pick_sample();
        w.right_in = pick_sample();
        w.num_frames = NUM_BITS'($urandom);
        pick = $urandom_range(99);
        if (pick < 45) begin
            w.op = OP_WRITE;
        end else if (pick < 82) begin
            w.op = OP_READ;
            if ($urandom_range(4) != 0) begin
                if (ratio_q == 0) begin
                    room = MAX_BLK;
                end else begin
                    room = (longint'(ring_held) * 65536) / longint'(ratio_q);
                end
                if (room > MAX_BLK) begin
                    room = MAX_BLK;
                end
                if ($urandom_range(2) == 0) begin
                    w.num_frames = NUM_BITS'(room);
                end else begin
                    w.num_frames = NUM_BITS'($urandom_range(int'(room)));
                end
            end
        end else if (pick < 86) begin
            w.op = OP_CLEAR;
        end else begin
            w.op = OP_QUERY;
        end
        return w;
    endfunction

    // Offer one word, hold it until taken, then queue what it must produce.
    task automatic put_word(input t_in_word w, input logic typed, input t_out_word want);
        if (send_pct > 0 && $urandom_range(99) < send_pct) begin
            in_valid = 1'b0;
            repeat (gap_len()) @(negedge clk);
        end
        in_data = w;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_word(w);
        if (typed) begin
            expected_words.push_back(want);
        end else begin
            foreach (pred_words[k]) expected_words.push_back(pred_words[k]);
        end
        @(negedge clk);
    endtask

    task automatic set_ratio(input logic [RATIO_BITS-1:0] value);
        in_valid = 1'b0;
        while (expected_words.size() != 0) @(negedge clk);
        repeat (12) @(negedge clk);
        cfg_data = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        ratio_q = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= 40) begin
            $display("mismatch in %s at output word %0d: got %0d, want %0d",
                     what, words_seen, got, want);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_words.size() == 0) begin
                flag_mismatch("word with nothing pending", 0, 0);
            end else begin
                head_word = expected_words.pop_front();
                if (out_data.left_out !== head_word.left_out)
                    flag_mismatch("left_out", out_data.left_out, head_word.left_out);
                if (out_data.right_out !== head_word.right_out)
                    flag_mismatch("right_out", out_data.right_out, head_word.right_out);
                if (out_data.last !== head_word.last)
                    flag_mismatch("last", out_data.last, head_word.last);
                if (out_data.status !== head_word.status)
                    flag_mismatch("status", out_data.status, head_word.status);
                if (out_data.frames_consumed !== head_word.frames_consumed)
                    flag_mismatch("frames_consumed", out_data.frames_consumed,
                                  head_word.frames_consumed);
                if (out_data.frames_available !== head_word.frames_available)
                    flag_mismatch("frames_available", out_data.frames_available,
                                  head_word.frames_available);
            end
            words_seen++;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int stall_left;
        int hold_off_done;
        stall_left = 0;
        hold_off_done = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_asks != hold_off_done) begin
                hold_off_done = hold_off_asks;
                stall_left = HOLD_OFF_LEN;
            end
            if (stall_left > 0) begin
                out_stall = 1'b1;
                stall_left--;
            end else begin
                out_stall = 1'b0;
                if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
                    stall_left = gap_len();
                end
            end
        end
    end

    initial begin
        t_out_word want;
        t_in_word  w;
        int        p;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        send_pct = 0;
        stall_pct = 0;
        hold_off_asks = 0;
        foreach (ring_left[k]) begin
            ring_left[k] = '0;
            ring_right[k] = '0;
        end
        ring_rd = 0;
        ring_wr = 0;
        ring_held = 0;
        ratio_q = RATIO_UNITY;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        set_ratio(RATIO_UNITY);
        send_pct = 20;
        stall_pct = 20;
        foreach (plan[r]) begin
            w.op = plan[r].op;
            w.left_in = plan[r].left;
            w.right_in = plan[r].right;
            w.num_frames = plan[r].num;
            want = '0;
            want.last = 1'b1;
            want.status = plan[r].status;
            want.frames_available = plan[r].avail;
            put_word(w, plan[r].typed, want);
        end

        for (p = 0; p < 9; p++) begin
            if (ratio_list[p] < 0) begin
                set_ratio(RATIO_BITS'($urandom_range(20'hFFFFF, 1)));
            end else begin
                set_ratio(RATIO_BITS'(ratio_list[p]));
            end
            send_pct = (p % 3 == 1) ? 0 : 25;
            stall_pct = (p % 3 == 2) ? 0 : 25;
            if (p == 0) begin
                hold_off_asks++;
            end
            repeat (43) put_word(random_word(), 1'b0, '0);
        end

        in_valid = 1'b0;
        while (expected_words.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
